// ----- sv/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and helpers for the sliding window min/max block
// Sample widths, the per-cell state record and signed min/max helpers.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WIN_SIZE_W     = 11;
  localparam int MAX_WINDOW_DEF = 1024;

  // State of one cell: the extremes over the newest (index + 1) samples of the
  // current sequence, valid once that many samples have arrived.
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] mn;
    logic signed [SAMPLE_W-1:0] mx;
  } swmm_cell_t;

  function automatic logic signed [SAMPLE_W-1:0] smin(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] smax(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/swmm_cell.sv -----
// ----------------------------------------------------------------------------
// swmm_cell: one stage of the running min/max chain
// Folds the incoming sample into the extremes handed over by its neighbor.
// ----------------------------------------------------------------------------
module swmm_cell
  import swmm_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       sos_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  swmm_cell_t                 prev_i,
  output swmm_cell_t                 cell_o
);

  logic       vld_q, vld_d;
  logic       inherit;
  swmm_cell_t data_q, data_d;

  // The neighbor's extremes belong to this sequence only if no restart came.
  assign inherit = !FIRST && prev_i.vld && !sos_i;

  always_comb begin
    vld_d       = FIRST ? 1'b1 : inherit;
    data_d.vld  = vld_d;
    data_d.mn   = inherit ? smin(sample_i, prev_i.mn) : sample_i;
    data_d.mx   = inherit ? smax(sample_i, prev_i.mx) : sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

// ----- sv/swmm_tap.sv -----
// ----------------------------------------------------------------------------
// swmm_tap: window tap and result merge
// Picks the cell one short of the window and folds in the new sample.
// ----------------------------------------------------------------------------
module swmm_tap
  import swmm_pkg::*;
#(
  parameter int NUM_CELLS = MAX_WINDOW_DEF,
  parameter int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
  input  swmm_cell_t [NUM_CELLS-1:0] cells_i,
  input  logic       [IDX_W-1:0]     sel_i,
  input  logic                       first_i,
  input  logic                       sos_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output swmm_cell_t                 res_o
);

  swmm_cell_t tap;

  assign tap = cells_i[sel_i];

  always_comb begin
    if (first_i) begin
      res_o.vld = 1'b1;
      res_o.mn  = sample_i;
      res_o.mx  = sample_i;
    end else begin
      res_o.vld = tap.vld && !sos_i;
      res_o.mn  = smin(sample_i, tap.mn);
      res_o.mx  = smax(sample_i, tap.mx);
    end
  end

endmodule

// ----- sv/sliding_window_min_max.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_max: running min and max over a sliding sample window
// A chain of cells keeps the extremes of the newest 1..MAX_WINDOW samples;
// the window size picks which cell feeds the result.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | sample_i, start_of_sequence_i
//   out     | source    | out_valid_o/out_stall_i | window_min_o, window_max_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_window_size_i
//
// One sample beat is taken per clock while the input is not stalled; its result
// beat, if any, appears in the output register in the cycle after acceptance.
// Every cell past cell zero updates from its neighbor in the same cycle.
// Reset clears the cell valid flags, the output valid and sets the window to 1.
// The input stalls only while a result is held and the output side stalls.
// Configuration beats are always taken.
//
// Cell k holds the min and max of the newest k+1 samples of the current
// sequence. A new sample shifts every cell one step: cell k takes the
// extremes of cell k-1 merged with the sample. A result for window w is
// therefore cell w-2 (before the update) merged with the sample, and exists
// when that cell was valid. This needs no sample store and stays correct when
// the window size is changed in the middle of a sequence.
// ----------------------------------------------------------------------------
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SAMPLE_W-1:0]   sample_i,
  input  logic                         start_of_sequence_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SAMPLE_W-1:0]   window_min_o,
  output logic signed [SAMPLE_W-1:0]   window_max_o,
  // window size register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [WIN_SIZE_W-1:0] cfg_window_size_i
);

  localparam int IdxW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MaxW  = $clog2(MAX_WINDOW + 1);
  localparam int EffW  = (MaxW > WIN_SIZE_W) ? MaxW : WIN_SIZE_W;

  // Window register, kept in decoded form: a flag for a window of one and
  // the index of the cell one short of the window.
  logic            win_first_q, win_first_d;
  logic [IdxW-1:0] win_tap_q, win_tap_d;
  logic [EffW-1:0] win_eff;

  assign cfg_ready_o = 1'b1;

  // A size of zero acts as one, and a size above the chain length is clamped.
  always_comb begin
    win_eff = EffW'(cfg_window_size_i);
    if (win_eff == '0) begin
      win_eff = EffW'(1);
    end
    if (win_eff > EffW'(MAX_WINDOW)) begin
      win_eff = EffW'(MAX_WINDOW);
    end
    win_first_d = (win_eff == EffW'(1));
    win_tap_d   = win_first_d ? '0 : IdxW'(win_eff - EffW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_first_q <= 1'b1;
      win_tap_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_first_q <= win_first_d;
      win_tap_q   <= win_tap_d;
    end
  end

  // Handshakes. The output register is the only buffer, so a new sample is
  // taken whenever that register is empty or draining this cycle.
  logic out_vld_q;
  logic in_fire;
  logic out_fire;

  assign in_stall_o = out_vld_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_vld_q && !out_stall_i;

  // Cell chain. Cell zero always restarts from the new sample.
  swmm_cell_t [MAX_WINDOW-1:0] cells;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swmm_cell_t prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = cells[k-1];
    end

    swmm_cell #(
      .FIRST (k == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_fire),
      .sos_i    (start_of_sequence_i),
      .sample_i (sample_i),
      .prev_i   (prev),
      .cell_o   (cells[k])
    );
  end

  // Result for the current window size, formed from the pre-update chain.
  swmm_cell_t res;

  swmm_tap #(
    .NUM_CELLS (MAX_WINDOW),
    .IDX_W     (IdxW)
  ) u_tap (
    .cells_i  (cells),
    .sel_i    (win_tap_q),
    .first_i  (win_first_q),
    .sos_i    (start_of_sequence_i),
    .sample_i (sample_i),
    .res_o    (res)
  );

  // Output register.
  logic signed [SAMPLE_W-1:0] min_q;
  logic signed [SAMPLE_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_fire && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.vld) begin
      min_q <= res.mn;
      max_q <= res.mx;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign window_min_o = min_q;
  assign window_max_o = max_q;

endmodule

// ----- sv/swmm_checker.sv -----
// ----------------------------------------------------------------------------
// swmm_checker: port-level checks for the sliding window min/max block
// Watches the handshakes and result beats of the top level.
// ----------------------------------------------------------------------------
module swmm_checker
  import swmm_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [SAMPLE_W-1:0] window_min_o,
  input logic signed [SAMPLE_W-1:0] window_max_o
);

  // A held result stays offered while the output side stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(window_min_o) && $stable(window_max_o))
    else $error("result payload changed while stalled");

  // The input only stalls when the result register is full and blocked.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A new result beat needs a sample beat accepted in the cycle before.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result beat without an accepted sample");

  // The window minimum never exceeds the window maximum.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_min_o <= window_max_o)
    else $error("window minimum above window maximum");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);
